FILE: sv/swr_pkg.sv
package swr_pkg;

   localparam int unsigned SEQ_W = 32;
   localparam int unsigned CONN_W = 16;
   localparam int unsigned WIN_REG_W = 5;
   localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 5'd10;

   localparam int unsigned PC_W = 4;

   typedef enum logic [1:0] {
      PT_START = 2'd0,
      PT_END   = 2'd1,
      PT_DATA  = 2'd2,
      PT_ACK   = 2'd3
   } ptype_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_DELIVER = 2'd1,
      KIND_CLOSED  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CLS_DROP    = 3'd0,
      CLS_START   = 3'd1,
      CLS_DATA_IN = 3'd2,
      CLS_BUF     = 3'd3,
      CLS_END     = 3'd4
   } class_type;

   typedef enum logic [2:0] {
      OP_NOP     = 3'd0,
      OP_OPEN    = 3'd1,
      OP_ADVANCE = 3'd2,
      OP_MARK    = 3'd3,
      OP_CLOSE   = 3'd4
   } dp_op_type;

   typedef enum logic [1:0] {
      VAL_ZERO     = 2'd0,
      VAL_EXPECTED = 2'd1,
      VAL_DONE     = 2'd2
   } val_sel_type;

   typedef enum logic [1:0] {
      COND_ALWAYS = 2'd0,
      COND_NO_REQ = 2'd1,
      COND_MORE   = 2'd2,
      COND_CLASS  = 2'd3
   } cond_type;

   typedef struct packed {
      cond_type          cond;
      logic [PC_W-1:0]   target;
      dp_op_type         op;
      logic              emit;
      kind_type          kind;
      val_sel_type       vsel;
      logic              last;
      logic              ready;
   } uword_type;

   typedef struct packed {
      logic        accept;
      dp_op_type   op;
      logic        emit;
      kind_type    kind;
      val_sel_type vsel;
      logic        last;
   } dp_ctrl_type;

   typedef struct packed {
      class_type pkt_class;
      logic      more;
      logic      out_free;
   } dp_status_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
   localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
   localparam logic [PC_W-1:0] PC_JTAB     = 4'd2;  // + class
   localparam logic [PC_W-1:0] PC_J_DROP   = 4'd2;
   localparam logic [PC_W-1:0] PC_J_START  = 4'd3;
   localparam logic [PC_W-1:0] PC_J_DATA   = 4'd4;
   localparam logic [PC_W-1:0] PC_J_BUF    = 4'd5;
   localparam logic [PC_W-1:0] PC_J_END    = 4'd6;
   localparam logic [PC_W-1:0] PC_DELIVER  = 4'd7;
   localparam logic [PC_W-1:0] PC_ACK      = 4'd8;
   localparam logic [PC_W-1:0] PC_CLOSE    = 4'd9;
   localparam int unsigned UC_DEPTH = 10;

   function automatic uword_type swr_ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{cond: COND_ALWAYS, target: PC_FETCH, op: OP_NOP, emit: 1'b0,
            kind: KIND_ACK, vsel: VAL_ZERO, last: 1'b0, ready: 1'b0};
      case (pc)
         PC_FETCH: begin
            w.cond   = COND_NO_REQ;
            w.target = PC_FETCH;
            w.ready  = 1'b1;
         end
         PC_DISPATCH: begin
            w.cond   = COND_CLASS;
            w.target = PC_JTAB;
         end
         PC_J_DROP: begin
            w.target = PC_FETCH;
         end
         PC_J_START: begin
            w.op   = OP_OPEN;
            w.emit = 1'b1;
            w.kind = KIND_ACK;
            w.vsel = VAL_ZERO;
            w.last = 1'b1;
         end
         PC_J_DATA: begin
            w.target = PC_DELIVER;
         end
         PC_J_BUF: begin
            w.op   = OP_MARK;
            w.emit = 1'b1;
            w.kind = KIND_ACK;
            w.vsel = VAL_EXPECTED;
            w.last = 1'b1;
         end
         PC_J_END: begin
            w.target = PC_CLOSE;
            w.emit   = 1'b1;
            w.kind   = KIND_ACK;
            w.vsel   = VAL_EXPECTED;
         end
         PC_DELIVER: begin
            // loops while the next buffered word is present
            w.cond   = COND_MORE;
            w.target = PC_DELIVER;
            w.op     = OP_ADVANCE;
            w.emit   = 1'b1;
            w.kind   = KIND_DELIVER;
            w.vsel   = VAL_EXPECTED;
         end
         PC_ACK: begin
            w.emit = 1'b1;
            w.kind = KIND_ACK;
            w.vsel = VAL_EXPECTED;
            w.last = 1'b1;
         end
         PC_CLOSE: begin
            w.op   = OP_CLOSE;
            w.emit = 1'b1;
            w.kind = KIND_CLOSED;
            w.vsel = VAL_DONE;
            w.last = 1'b1;
         end
         default: begin
            w.target = PC_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: sv/swr_req_if.sv
interface swr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  packet_type;
   logic [31:0] seq_num;
   logic        checksum_ok;

   modport source (output valid, output packet_type, output seq_num, output checksum_ok,
                   input ready);
   modport sink (input valid, input packet_type, input seq_num, input checksum_ok,
                 output ready);
endinterface

FILE: sv/swr_rsp_if.sv
interface swr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] event_value;
   logic        last_event;

   modport source (output valid, output event_kind, output event_value, output last_event,
                   input ready);
   modport sink (input valid, input event_kind, input event_value, input last_event,
                 output ready);
endinterface

FILE: sv/sliding_window_receiver.sv
// channel  dir  handshake            payload
// req_if   in   valid/ready          packet_type, seq_num, checksum_ok
// rsp_if   out  valid/ready          event_kind, event_value, last_event
// csr      in   csr_wr_en            csr_wr_data (window_size)
//
// Each req word runs through a microprogram, one step per cycle while no result
// stalls it; in-order DATA also delivers the buffered words that follow it, one
// result a cycle while draining unless rsp_if holds a result back.
// A result stalled on rsp_if holds the program at its next emitting step;
// a new req word is taken while the last result still waits.
// Reset is synchronous and clears all connection state, window_size to 10.
module sliding_window_receiver #(
   parameter int unsigned MAX_WINDOW = 16
) (
   input  logic        clock,
   input  logic        reset,
   swr_req_if.sink     req_if,
   swr_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import swr_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   swr_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   swr_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .packet_type     (req_if.packet_type),
      .seq_num         (req_if.seq_num),
      .checksum_ok     (req_if.checksum_ok),
      .ctrl            (ctrl),
      .status          (status),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_event_kind  (rsp_if.event_kind),
      .rsp_event_value (rsp_if.event_value),
      .rsp_last_event  (rsp_if.last_event)
   );

endmodule

FILE: sv/swr_sequencer.sv
module swr_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  swr_pkg::dp_status_type   status,
   output swr_pkg::dp_ctrl_type     ctrl
);
   import swr_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   uword_type       uword;
   logic            fire;
   logic            cond_true;

   always_comb begin
      uword = swr_ucode(pc_ff);
      fire  = !uword.emit || status.out_free;

      case (uword.cond)
         COND_ALWAYS: cond_true = 1'b1;
         COND_NO_REQ: cond_true = !req_valid;
         COND_MORE:   cond_true = status.more;
         default:     cond_true = 1'b0;
      endcase

      if (!fire) begin
         pc_in = pc_ff;
      end else if (uword.cond == COND_CLASS) begin
         pc_in = uword.target + PC_W'(status.pkt_class);
      end else if (cond_true) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end

      req_ready   = uword.ready && !reset;
      ctrl.accept = req_valid && req_ready;
      ctrl.op     = fire ? uword.op : OP_NOP;
      ctrl.emit   = uword.emit && fire;
      ctrl.kind   = uword.kind;
      ctrl.vsel   = uword.vsel;
      ctrl.last   = uword.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

`ifndef SYNTHESIS
   a_pc_in_rom: assert property (@(posedge clock) disable iff (reset)
      pc_ff < PC_W'(UC_DEPTH))
      else $error("sequencer left the program");
`endif

endmodule

FILE: sv/swr_datapath.sv
module swr_datapath #(
   parameter int unsigned MAX_WINDOW = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [4:0]               csr_wr_data,
   input  logic [1:0]               packet_type,
   input  logic [31:0]              seq_num,
   input  logic                     checksum_ok,
   input  swr_pkg::dp_ctrl_type     ctrl,
   output swr_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_event_kind,
   output logic [31:0]              rsp_event_value,
   output logic                     rsp_last_event
);
   import swr_pkg::*;

   localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [WIN_REG_W-1:0]  window_ff, window_in;
   logic                  open_ff, open_in;
   logic [SEQ_W-1:0]      expected_ff, expected_in;
   logic [SEQ_W-1:0]      opening_ff, opening_in;
   logic [MAX_WINDOW-1:0] bitmap_ff, bitmap_in;
   logic [CONN_W-1:0]     done_ff, done_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   ptype_type             ptype_ff;
   logic [SEQ_W-1:0]      seq_ff;
   logic                  ok_ff;
   logic [1:0]            kind_ff;
   logic [SEQ_W-1:0]      value_ff;
   logic                  last_ff;

   logic [SEQ_W-1:0]      offset;
   logic [SEQ_W-1:0]      win;
   logic [MAX_WINDOW-1:0] bitmap_shr;
   logic [SEQ_W-1:0]      emit_value;
   class_type             pkt_class;

   always_comb begin
      offset     = seq_ff - expected_ff;
      bitmap_shr = bitmap_ff >> 1;
      if (window_ff == '0) begin
         win = SEQ_W'(1);
      end else if (SEQ_W'(window_ff) > SEQ_W'(MAX_WINDOW)) begin
         win = SEQ_W'(MAX_WINDOW);
      end else begin
         win = SEQ_W'(window_ff);
      end

      pkt_class = CLS_DROP;
      if (ptype_ff == PT_START) begin
         if (!open_ff) pkt_class = CLS_START;
      end else if (open_ff && ptype_ff == PT_DATA && ok_ff) begin
         if (offset == '0) begin
            pkt_class = CLS_DATA_IN;
         end else if (offset < win) begin
            pkt_class = CLS_BUF;
         end
      end else if (open_ff && ptype_ff == PT_END && seq_ff == opening_ff) begin
         pkt_class = CLS_END;
      end

      status.pkt_class = pkt_class;
      status.more      = bitmap_shr[0];
      status.out_free  = !rsp_valid_ff || rsp_ready;

      case (ctrl.vsel)
         VAL_EXPECTED: emit_value = expected_ff;
         VAL_DONE:     emit_value = SEQ_W'(done_ff);
         default:      emit_value = '0;
      endcase
   end

   always_comb begin
      window_in   = csr_wr_en ? csr_wr_data : window_ff;
      open_in     = open_ff;
      expected_in = expected_ff;
      opening_in  = opening_ff;
      bitmap_in   = bitmap_ff;
      done_in     = done_ff;
      case (ctrl.op)
         OP_OPEN: begin
            open_in     = 1'b1;
            expected_in = '0;
            opening_in  = seq_ff;
            bitmap_in   = '0;
         end
         OP_ADVANCE: begin
            expected_in = expected_ff + 1'b1;
            bitmap_in   = bitmap_shr;
         end
         OP_MARK: begin
            bitmap_in = bitmap_ff | (MAX_WINDOW'(1) << offset[IDX_W-1:0]);
         end
         OP_CLOSE: begin
            open_in = 1'b0;
            done_in = done_ff + 1'b1;
         end
         default: begin
         end
      endcase

      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         open_ff      <= 1'b0;
         expected_ff  <= '0;
         opening_ff   <= '0;
         bitmap_ff    <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         open_ff      <= open_in;
         expected_ff  <= expected_in;
         opening_ff   <= opening_in;
         bitmap_ff    <= bitmap_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         ptype_ff <= ptype_type'(packet_type);
         seq_ff   <= seq_num;
         ok_ff    <= checksum_ok;
      end
      if (ctrl.emit) begin
         kind_ff  <= ctrl.kind;
         value_ff <= emit_value;
         last_ff  <= ctrl.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_value = value_ff;
   assign rsp_last_event  = last_ff;

`ifndef SYNTHESIS
   // bit 0 is only set while the drain loop is delivering that word
   a_bit0_clear: assert property (@(posedge clock) disable iff (reset)
      bitmap_ff[0] |-> ctrl.kind == KIND_DELIVER)
      else $error("expected word marked as buffered outside a drain");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> status.out_free)
      else $error("result word overwritten");

   a_close_counts: assert property (@(posedge clock) disable iff (reset)
      $fell(open_ff) && !$past(reset) |-> done_ff == $past(done_ff) + 1'b1)
      else $error("close without count");

   a_idle_no_bits: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_MARK || ctrl.op == OP_ADVANCE |-> open_ff)
      else $error("window update while idle");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import swr_pkg::*;

   localparam int unsigned WIN_MAX     = 16;
   localparam int          STALL_LIMIT = 2000;
   localparam int          HOLD_CYCLES = 300;

   typedef struct packed {
      kind_type         kind;
      logic [SEQ_W-1:0] value;
      logic             last;
   } event_word_type;

   typedef enum int {
      RX_ALWAYS,
      RX_MOSTLY,
      RX_PATTERN,
      RX_COIN
   } rx_mode_type;

   class ack_tracker;
      logic [WIN_REG_W-1:0] window_reg;
      bit                   conn_open;
      logic [SEQ_W-1:0]     next_seq;
      logic [SEQ_W-1:0]     open_seq;
      logic [WIN_MAX-1:0]   arrived;
      logic [CONN_W-1:0]    closed_count;
      event_word_type       due_events[$];
      int                   errors;
      int                   noted;

      function new();
         window_reg   = WINDOW_RESET;
         conn_open    = 1'b0;
         next_seq     = '0;
         open_seq     = '0;
         arrived      = '0;
         closed_count = '0;
         errors       = 0;
         noted        = 0;
      endfunction

      function int span();
         if (window_reg == 0) return 1;
         if (window_reg > WIN_MAX) return WIN_MAX;
         return int'(window_reg);
      endfunction

      function void add_event(kind_type kind, logic [SEQ_W-1:0] value);
         event_word_type e;
         e.kind  = kind;
         e.value = value;
         e.last  = 1'b0;
         due_events.push_back(e);
      endfunction

      function void note_packet(ptype_type ptype, logic [SEQ_W-1:0] seq, logic ok);
         int               queued_n;
         logic [SEQ_W-1:0] offset;
         event_word_type   tail;
         queued_n = due_events.size();
         offset   = seq - next_seq;
         noted++;
         case (ptype)
            PT_START: if (!conn_open) begin
               conn_open = 1'b1;
               next_seq  = '0;
               open_seq  = seq;
               arrived   = '0;
               add_event(KIND_ACK, '0);
            end
            PT_DATA: if (conn_open && ok && offset < span()) begin
               if (offset == 0) begin
                  add_event(KIND_DELIVER, next_seq);
                  next_seq++;
                  arrived = arrived >> 1;
                  while (arrived[0]) begin
                     add_event(KIND_DELIVER, next_seq);
                     next_seq++;
                     arrived = arrived >> 1;
                  end
               end else begin
                  arrived[offset[$clog2(WIN_MAX)-1:0]] = 1'b1;
               end
               add_event(KIND_ACK, next_seq);
            end
            PT_END: if (conn_open && seq == open_seq) begin
               add_event(KIND_ACK, next_seq);
               add_event(KIND_CLOSED, {{(SEQ_W-CONN_W){1'b0}}, closed_count});
               closed_count++;
               conn_open = 1'b0;
            end
            default: ;
         endcase
         if (due_events.size() > queued_n) begin
            tail      = due_events.pop_back();
            tail.last = 1'b1;
            due_events.push_back(tail);
         end
      endfunction

      task report(string msg);
         if (errors < 40) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_event(logic [1:0] kind, logic [SEQ_W-1:0] value, logic last);
         event_word_type want;
         if (due_events.size() == 0) begin
            report($sformatf("unexpected word kind %0d value %h last %b", kind, value, last));
            return;
         end
         want = due_events.pop_front();
         if (kind !== want.kind)
            report($sformatf("event_kind %0d, want %0d (value %h)", kind, want.kind, want.value));
         if (value !== want.value)
            report($sformatf("event_value %h, want %h (kind %0d)", value, want.value, want.kind));
         if (last !== want.last)
            report($sformatf("last_event %b, want %b (kind %0d value %h)", last, want.last,
                             want.kind, want.value));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [WIN_REG_W-1:0] csr_wr_data;

   swr_req_if req();
   swr_rsp_if rsp();

   sliding_window_receiver #(.MAX_WINDOW(WIN_MAX)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req),
      .rsp_if      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ack_tracker  sb;
   int          burst_left;
   int          gap_max;
   rx_mode_type rx_mode;
   logic [7:0]  rx_pattern;
   bit          hold_req;

   always #5 clock = ~clock;

   task automatic send_word(ptype_type ptype, logic [SEQ_W-1:0] seq, logic ok);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req.valid       <= 1'b1;
      req.packet_type <= ptype;
      req.seq_num     <= seq;
      req.checksum_ok <= ok;
      do @(posedge clock); while (req.ready !== 1'b1);
      sb.note_packet(ptype, seq, ok);
      burst_left--;
   endtask

   // stop offering, wait out every pending event, then let a dropped word finish
   task automatic drain();
      req.valid <= 1'b0;
      burst_left = 0;
      while (sb.due_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_REG_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      sb.window_reg = val;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_data();
      int               w;
      int               r;
      logic [SEQ_W-1:0] base;
      logic [SEQ_W-1:0] seq;
      logic             ok;
      w    = sb.span();
      base = sb.next_seq;
      r    = $urandom_range(0, 99);
      ok   = 1'b1;
      seq  = base;
      if (r < 40) begin
         seq = base;
      end else if (r < 68) begin
         seq = base + $urandom_range(0, w - 1);
      end else if (r < 76) begin
         seq = base + w + $urandom_range(0, 4);
      end else if (r < 84) begin
         seq = base - $urandom_range(1, 4);
      end else if (r < 92) begin
         seq = base + $urandom_range(0, w - 1);
         ok  = 1'b0;
      end else if (r < 97) begin
         seq = $urandom;
         ok  = 1'($urandom_range(0, 1));
      end else begin
         send_word(PT_ACK, $urandom, 1'($urandom_range(0, 1)));
         return;
      end
      send_word(PT_DATA, seq, ok);
   endtask

   // buffer the whole window top down, then release it with the expected word
   task automatic fill_window();
      int               w;
      logic [SEQ_W-1:0] base;
      w    = sb.span();
      base = sb.next_seq;
      for (int off = w - 1; off >= 1; off--) send_word(PT_DATA, base + off, 1'b1);
      send_word(PT_DATA, base, 1'b1);
   endtask

   task automatic run_session();
      int               n;
      logic [1:0]       t;
      logic [SEQ_W-1:0] start_seq;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            t = 2'($urandom_range(0, 3));
            send_word(ptype_type'(t), $urandom, 1'($urandom_range(0, 1)));
         end
      end
      start_seq = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
      send_word(PT_START, start_seq, 1'($urandom_range(0, 1)));
      n = $urandom_range(1, 24);
      repeat (n) begin
         if (sb.span() > 1 && $urandom_range(0, 19) == 0) fill_window();
         else send_data();
      end
      if ($urandom_range(0, 4) == 0)
         send_word(PT_END, sb.open_seq ^ (32'h1 << $urandom_range(0, 31)), 1'b1);
      if ($urandom_range(0, 9) != 0)
         send_word(PT_END, sb.open_seq, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int extremes[5];
      int phase;
      extremes = '{0, 1, 16, 17, 31};
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req.valid       <= 1'b0;
      req.packet_type <= PT_START;
      req.seq_num     <= '0;
      req.checksum_ok <= 1'b0;
      sb         = new();
      burst_left = 0;
      gap_max    = 3;
      rx_mode    = RX_MOSTLY;
      rx_pattern = 8'h5b;
      hold_req   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // idle: everything but START is ignored
      send_word(PT_DATA, 32'h0, 1'b1);
      send_word(PT_END, 32'h0, 1'b1);
      send_word(PT_ACK, 32'h0, 1'b1);
      send_word(PT_START, 32'hffff_ffff, 1'b0);
      send_word(PT_START, 32'h0, 1'b1);
      send_word(PT_ACK, 32'h0, 1'b1);
      send_word(PT_DATA, 32'h0, 1'b0);
      send_word(PT_DATA, 32'h0, 1'b1);
      send_word(PT_DATA, 32'h0, 1'b1);
      send_word(PT_DATA, 32'h3, 1'b1);
      send_word(PT_DATA, 32'h3, 1'b1);
      send_word(PT_DATA, 32'h2, 1'b1);
      send_word(PT_DATA, 32'ha, 1'b1);
      send_word(PT_DATA, 32'hb, 1'b1);
      send_word(PT_DATA, 32'h1, 1'b1);
      send_word(PT_END, 32'h0, 1'b1);
      send_word(PT_END, 32'hffff_ffff, 1'b1);
      drain();
      write_window(5'd0);
      send_word(PT_START, 32'h0, 1'b1);
      send_word(PT_DATA, 32'h1, 1'b1);
      send_word(PT_DATA, 32'h0, 1'b1);
      send_word(PT_END, 32'h0, 1'b1);

      phase = 0;
      while (sb.noted < 300) begin
         drain();
         write_window(WIN_REG_W'(phase < 5 ? extremes[phase] : $urandom_range(0, 31)));
         rx_mode    = rx_mode_type'($urandom_range(0, 3));
         rx_pattern = 8'($urandom) | 8'h01;
         gap_max    = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
         if (phase == 1 || $urandom_range(0, 9) == 0) hold_req = 1'b1;
         repeat ($urandom_range(1, 3)) run_session();
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.due_events.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      int tick;
      tick = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_req) begin
            hold_req = 1'b0;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case (rx_mode)
               RX_ALWAYS:  rsp.ready <= 1'b1;
               RX_MOSTLY:  rsp.ready <= ($urandom_range(0, 3) != 0);
               RX_PATTERN: rsp.ready <= rx_pattern[tick % 8];
               default:    rsp.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
         sb.check_event(rsp.event_kind, rsp.event_value, rsp.last_event);
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req.valid === 1'b1 && req.ready === 1'b1) ||
             (rsp.valid === 1'b1 && rsp.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top: errors");
      $finish;
   end

endmodule
